### hw/rtl/bounded_deque_with_search_top_macros.svh
// Assertion helpers for the deque block.
// BDQ_ASSERT_IMP: same-cycle implication, BDQ_ASSERT_NXT: next-cycle implication.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BDQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque assertion failed");
`define BDQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque assertion failed");
`else
`define BDQ_ASSERT_IMP(lbl, ante, cons)
`define BDQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/bdq_pkg.sv
`timescale 1ns / 1ps
package bdq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_FIND       = 3'd5,
    CMD_READ_AT    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e     status;
    logic        found;
    logic [4:0]  position;
    logic [31:0] read_value;
    logic [5:0]  count;
  } res_t;

endpackage

### hw/rtl/bdq_mem.sv
`timescale 1ns / 1ps
module bdq_mem #(
  parameter int unsigned DEPTH       = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [VALUE_WIDTH-1:0]   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [VALUE_WIDTH-1:0]   rdata_o
);

  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bdq_seq.sv
`timescale 1ns / 1ps
module bdq_seq #(
  parameter int unsigned DEPTH       = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 command_i,
  input  logic [31:0]                value_i,
  input  logic [5:0]                 index_i,
  output logic                       we_o,
  output logic [$clog2(DEPTH)-1:0]   waddr_o,
  output logic [VALUE_WIDTH-1:0]     wdata_o,
  output logic                       re_o,
  output logic [$clog2(DEPTH)-1:0]   raddr_o,
  input  logic [VALUE_WIDTH-1:0]     rdata_i,
  output logic                       res_valid_o,
  output bdq_pkg::res_t              res_o,
  input  logic                       res_ready_i
);
  import bdq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > 6) ? CW : 6;
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST    = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [5:0]           idx_q, idx_d;
  logic [PW-1:0]        front_q, front_d;
  logic [CW-1:0]        count_q, count_d;
  logic [PW-1:0]        slot_q, slot_d;
  logic [CW-1:0]        rd_off_q, rd_off_d;
  logic [CW-1:0]        cmp_off_q, cmp_off_d;
  logic                 cmp_valid_q, cmp_valid_d;
  res_t                 res_q, res_d;

  logic                 full, empty, hit;
  logic [PW:0]          back_sum, read_sum;
  logic [PW-1:0]        back_slot, read_slot, prev_front;
  logic [XW-1:0]        idx_x;

  assign full  = (count_q == FULL_CNT);
  assign empty = (count_q == '0);
  assign idx_x = XW'(idx_q);

  // ring address: sums stay below twice the depth, so one subtract wraps
  assign back_sum  = {1'b0, front_q} + {1'b0, count_q[PW-1:0]};
  assign back_slot = (back_sum >= DEPTH_W) ? PW'(back_sum - DEPTH_W) : PW'(back_sum);
  assign read_sum  = {1'b0, front_q} + {1'b0, idx_x[PW-1:0]};
  assign read_slot = (read_sum >= DEPTH_W) ? PW'(read_sum - DEPTH_W) : PW'(read_sum);
  assign prev_front = (front_q == '0) ? LAST : front_q - PW'(1);

  assign hit = cmp_valid_q && (rdata_i == val_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      cmp_valid_q <= cmp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    slot_q    <= slot_d;
    rd_off_q  <= rd_off_d;
    cmp_off_q <= cmp_off_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    idx_d       = idx_q;
    front_d     = front_q;
    count_d     = count_q;
    slot_d      = slot_q;
    rd_off_d    = rd_off_q;
    cmp_off_d   = cmp_off_q;
    cmp_valid_d = 1'b0;
    res_d       = res_q;
    we_o        = 1'b0;
    waddr_o     = back_slot;
    wdata_o     = val_q;
    re_o        = 1'b0;
    raddr_o     = slot_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(command_i);
          val_d   = VALUE_WIDTH'(value_i);
          idx_d   = index_i;
          res_d   = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (cmd_q)
          CMD_PUSH_BACK: begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              we_o    = 1'b1;
              count_d = count_q + CW'(1);
            end
          end
          CMD_PUSH_FRONT: begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              we_o    = 1'b1;
              waddr_o = prev_front;
              front_d = prev_front;
              count_d = count_q + CW'(1);
            end
          end
          CMD_POP_BACK: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
            end else begin
              count_d = count_q - CW'(1);
            end
          end
          CMD_POP_FRONT: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
            end else begin
              front_d = (front_q == LAST) ? '0 : front_q + PW'(1);
              count_d = count_q - CW'(1);
            end
          end
          CMD_CLEAR: begin
            front_d = '0;
            count_d = '0;
          end
          CMD_FIND: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
            end else begin
              slot_d   = front_q;
              rd_off_d = '0;
              state_d  = S_SCAN;
            end
          end
          CMD_READ_AT: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
            end else if (idx_x >= XW'(count_q)) begin
              res_d.status = ST_RANGE;
            end else begin
              re_o    = 1'b1;
              raddr_o = read_slot;
              state_d = S_RDWAIT;
            end
          end
          default: ;
        endcase
      end
      S_RDWAIT: begin
        res_d.read_value = 32'(rdata_i);
        state_d          = S_DONE;
      end
      S_SCAN: begin
        // one read issued per cycle, each compared against the registered RAM data
        if (rd_off_q < count_q) begin
          re_o        = 1'b1;
          cmp_valid_d = 1'b1;
          cmp_off_d   = rd_off_q;
          rd_off_d    = rd_off_q + CW'(1);
          slot_d      = (slot_q == LAST) ? '0 : slot_q + PW'(1);
        end
        if (hit) begin
          res_d.found    = 1'b1;
          res_d.position = 5'(cmp_off_q);
          cmp_valid_d    = 1'b0;
          state_d        = S_DONE;
        end else if (cmp_valid_q && ((cmp_off_q + CW'(1)) == count_q)) begin
          cmp_valid_d = 1'b0;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o       = res_q;
    res_o.count = 6'(count_q);
  end

endmodule

### hw/rtl/bounded_deque_with_search_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   command_i, value_i, index_i
// out      source     out_valid_o / out_stall_i status_o, found_o, position_o,
//                                               read_value_o, count_o
//
// Sequencing: push, pop, clear and unused codes pass through exec and done; an
// in-range read at adds a wait state for the registered RAM read; find steps the
// single RAM read port through the ring one entry per cycle until a hit or the end.
// Reset: count and front pointer clear; the element RAM is not cleared and needs
// no clearing pass, only written entries are ever read.
// Stalls: the result register lets the next command enter while a result waits;
// a finished command holds in the sequencer until that register frees.
module bounded_deque_with_search_top #(
  parameter int unsigned DEPTH       = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [4:0]  position_o,
  output logic [31:0] read_value_o,
  output logic [5:0]  count_o
);
  import bdq_pkg::*;

  `include "bounded_deque_with_search_top_macros.svh"

  localparam int unsigned PW = $clog2(DEPTH);

  // RAM port between sequencer and store
  logic                   we;
  logic [PW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic                   re;
  logic [PW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rdata;

  // finished result from sequencer
  logic res_valid, res_ready;
  res_t res;

  // output register
  logic out_valid_q, out_valid_d;
  res_t out_q, out_d;

  bdq_mem #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bdq_seq #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // result register is free when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign found_o      = out_q.found;
  assign position_o   = out_q.position;
  assign read_value_o = out_q.read_value;
  assign count_o      = out_q.count;

  // a taken command leaves the sequencer busy in the next cycle
  `BDQ_ASSERT_NXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)
  // a dropped push only happens with the store at capacity
  `BDQ_ASSERT_IMP(a_full_count, res_valid && (res.status == ST_FULL), res.count == 6'(DEPTH))
  // a hit is always an ok result with no read data
  `BDQ_ASSERT_IMP(a_hit_ok, res_valid && res.found,
                  (res.status == ST_OK) && (res.read_value == '0))
  // failed read returns nothing
  `BDQ_ASSERT_IMP(a_range_clean, res_valid && (res.status == ST_RANGE),
                  !res.found && (res.read_value == '0) && (res.position == '0))

endmodule
